// ===== rtl/task_state_ready_queue_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the task state and ready queue block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TASK_STATE_READY_QUEUE_ASSERT_SVH
`define TASK_STATE_READY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds in the cycle where ante holds.
`define TSRQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante holds.
`define TSRQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSRQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define TSRQ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/tsrq_pkg.sv =====
// ---------------------------------------------------------------------------
// tsrq_pkg
// Shared codes, widths and control types of the task ready queue.
// ---------------------------------------------------------------------------
package tsrq_pkg;

  localparam int unsigned MaxTasks = 64;
  localparam int unsigned TaskW    = $clog2(MaxTasks);
  localparam int unsigned CodeW    = 32;
  localparam int unsigned KindW    = 3;
  localparam int unsigned StateW   = 3;
  localparam int unsigned RcW      = 3;
  localparam int unsigned InDataW  = ((TaskW + CodeW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((TaskW + StateW + TaskW + 1 + 7) / 8) * 8;

  typedef logic [TaskW-1:0] task_t;

  localparam task_t RootTask = task_t'(1);

  typedef enum logic [KindW-1:0] {
    KIND_CREATE   = 3'd0,
    KIND_RESUME   = 3'd1,
    KIND_SUSPEND  = 3'd2,
    KIND_KILL     = 3'd3,
    KIND_YIELD    = 3'd4,
    KIND_DISPATCH = 3'd5
  } kind_e;

  typedef enum logic [StateW-1:0] {
    ST_UNUSED    = 3'd0,
    ST_SUSPENDED = 3'd1,
    ST_READY     = 3'd2,
    ST_RUNNING   = 3'd3,
    ST_WAITING   = 3'd4,
    ST_KILLED    = 3'd5
  } task_state_e;

  typedef enum logic [RcW-1:0] {
    RC_OK          = 3'd0,
    RC_ILLEGAL     = 3'd1,
    RC_EMPTY       = 3'd2,
    RC_INVALID     = 3'd3,
    RC_ROOT_KILLED = 3'd4
  } rc_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;     // capture the incoming word
    logic rd;      // read state and links of the target task
    logic commit;  // write back tables and load the result register
  } cmd_t;

endpackage

// ===== rtl/task_state_ready_queue.sv =====
// ---------------------------------------------------------------------------
// task_state_ready_queue
// Task table with a FIFO ready queue and create/resume/suspend/kill/
// yield/dispatch requests, one result word per request word.
// ---------------------------------------------------------------------------
// A request word is taken when the block is idle. Its result word is valid
// after the registered read of the task state and the prev/next link memories
// at the target task (the named task, the current task for yield, the queue
// head for dispatch), and the commit cycle that writes the tables and loads
// the result register. The commit waits while the previous result has not
// yet been taken downstream. Only one request is worked on at a time: the
// next request is taken right after the commit, even while the result still
// waits. The state table resets to unused through per-task valid bits, so no
// clearing pass follows reset.
`include "task_state_ready_queue_assert.svh"

module task_state_ready_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [5:0] task_index, [37:6] exit_code, upper bits zero
  input  logic [tsrq_pkg::InDataW-1:0]  s_axis_tdata,
  // [2:0] kind
  input  logic [tsrq_pkg::KindW-1:0]    s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] acted_task, [8:6] new_state, [14:9] running_task, [15] queue_is_empty
  output logic [tsrq_pkg::OutDataW-1:0] m_axis_tdata,
  // [2:0] status
  output logic [tsrq_pkg::RcW-1:0]      m_axis_tuser
);
  import tsrq_pkg::*;

  cmd_t        cmd;
  rc_e         status;
  task_t       acted_task;
  task_state_e new_state;
  task_t       running_task;
  logic        queue_is_empty;

  // Sequencer: owns both handshakes and paces the datapath.
  tsrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Tables, queue pointers and the result register.
  tsrq_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .kind_i           (s_axis_tuser),
    .task_index_i     (s_axis_tdata[TaskW-1:0]),
    .exit_code_i      (s_axis_tdata[TaskW+CodeW-1:TaskW]),
    .status_o         (status),
    .acted_task_o     (acted_task),
    .new_state_o      (new_state),
    .running_task_o   (running_task),
    .queue_is_empty_o (queue_is_empty)
  );

  // Pack the result word, lowest field first.
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[TaskW-1:0]                       = acted_task;
    m_axis_tdata[TaskW+StateW-1:TaskW]            = new_state;
    m_axis_tdata[2*TaskW+StateW-1:TaskW+StateW]   = running_task;
    m_axis_tdata[2*TaskW+StateW]                  = queue_is_empty;
  end
  assign m_axis_tuser = status;

  // A result is always pending once a taken request has passed its read and commit states.
  `TSRQ_ASSERT_IMP(a_result_follows, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready, ##3 m_axis_tvalid,
    "no result three cycles after a request")

  // Only one request is worked on at a time.
  `TSRQ_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "request taken while another is in flight")

  // An empty-queue status must report an empty queue.
  `TSRQ_ASSERT_IMP(a_empty_status, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == RC_EMPTY), queue_is_empty,
    "empty status with a nonempty queue")

  // No task acted on means no state reported.
  `TSRQ_ASSERT_IMP(a_idle_state, clk_i, rst_ni,
    m_axis_tvalid && (acted_task == '0), new_state == ST_UNUSED,
    "state reported for task zero")

endmodule

// ===== rtl/tsrq_ctrl.sv =====
// ---------------------------------------------------------------------------
// tsrq_ctrl
// Request sequencer: capture, table read, commit; owns both handshakes.
// ---------------------------------------------------------------------------
module tsrq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tsrq_pkg::cmd_t cmd_o
);
  import tsrq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   out_valid_q;

  assign cmd_o.cap    = ready_q & in_valid_i;
  assign cmd_o.rd     = (state_q == S_READ);
  // Hold the commit until the result register is free or being drained.
  assign cmd_o.commit = (state_q == S_EXEC) & (~out_valid_q | out_ready_i);

  assign in_ready_o  = ready_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.cap) begin
            state_q <= S_READ;
            ready_q <= 1'b0;
          end
        end
        S_READ: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd_o.commit) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/tsrq_datapath.sv =====
// ---------------------------------------------------------------------------
// tsrq_datapath
// Task state table, ready queue link memories, queue pointers and result.
// ---------------------------------------------------------------------------
module tsrq_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsrq_pkg::cmd_t        cmd_i,
  input  logic [2:0]            kind_i,
  input  tsrq_pkg::task_t       task_index_i,
  input  logic [31:0]           exit_code_i,
  output tsrq_pkg::rc_e         status_o,
  output tsrq_pkg::task_t       acted_task_o,
  output tsrq_pkg::task_state_e new_state_o,
  output tsrq_pkg::task_t       running_task_o,
  output logic                  queue_is_empty_o
);
  import tsrq_pkg::*;

  // Captured request.
  logic [KindW-1:0] kind_q;
  task_t            idx_q;
  logic [CodeW-1:0] code_q;

  // Queue and scheduler registers.
  task_t head_q, head_d;
  task_t tail_q, tail_d;
  logic  nonempty_q, nonempty_d;
  task_t cur_q, cur_d;

  // Tables.
  task_state_e      state_mem [MaxTasks];
  logic [MaxTasks-1:0] st_valid_q;
  task_t            prev_mem  [MaxTasks];
  task_t            next_mem  [MaxTasks];
  logic [CodeW-1:0] exit_mem  [MaxTasks];

  // Registered read data.
  task_state_e st_rd_q;
  task_t       prev_rd_q;
  task_t       next_rd_q;

  // Result register.
  rc_e         status_q;
  task_t       acted_q;
  task_state_e new_state_q;
  task_t       running_q;
  logic        empty_q;

  // Commit-cycle decisions.
  task_t       tgt;
  rc_e         rc;
  task_t       acted;
  logic        valid_idx;
  logic        st_we;
  task_t       st_wa;
  task_state_e st_wd;
  logic        ex_we;
  logic [CodeW-1:0] ex_wd;
  logic        do_push;
  logic        do_unlink;
  task_t       lt;
  logic        cur_clr;
  logic        cur_set;
  logic        prev_we;
  task_t       prev_wa;
  task_t       prev_wd;
  logic        next_we;
  task_t       next_wa;
  task_t       next_wd;
  task_state_e new_state;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q <= kind_i;
      idx_q  <= task_index_i;
      code_q <= exit_code_i;
    end
  end

  // Task whose state and links are fetched.
  always_comb begin
    case (kind_q)
      KIND_YIELD:    tgt = cur_q;
      KIND_DISPATCH: tgt = head_q;
      default:       tgt = idx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      st_rd_q   <= st_valid_q[tgt] ? state_mem[tgt] : ST_UNUSED;
      prev_rd_q <= prev_mem[tgt];
      next_rd_q <= next_mem[tgt];
    end
  end

  always_comb begin
    valid_idx = (idx_q != '0);
    rc        = RC_OK;
    acted     = idx_q;
    st_we     = 1'b0;
    st_wa     = idx_q;
    st_wd     = ST_UNUSED;
    ex_we     = 1'b0;
    ex_wd     = code_q;
    do_push   = 1'b0;
    do_unlink = 1'b0;
    lt        = idx_q;
    cur_clr   = 1'b0;
    cur_set   = 1'b0;
    case (kind_q)
      KIND_CREATE: begin
        if (!valid_idx) begin
          rc = RC_INVALID;
        end else if (st_rd_q != ST_UNUSED) begin
          rc = RC_ILLEGAL;
        end else begin
          st_we = 1'b1;
          st_wd = ST_SUSPENDED;
          ex_we = 1'b1;
          ex_wd = '0;
        end
      end
      KIND_RESUME: begin
        if (!valid_idx || st_rd_q == ST_UNUSED) begin
          rc = RC_INVALID;
        end else if (st_rd_q != ST_SUSPENDED) begin
          rc = RC_ILLEGAL;
        end else begin
          st_we   = 1'b1;
          st_wd   = ST_READY;
          do_push = 1'b1;
        end
      end
      KIND_SUSPEND: begin
        if (!valid_idx || st_rd_q == ST_UNUSED) begin
          rc = RC_INVALID;
        end else if (st_rd_q == ST_KILLED) begin
          rc = RC_ILLEGAL;
        end else if (st_rd_q != ST_SUSPENDED) begin
          do_unlink = (st_rd_q == ST_READY);
          st_we     = 1'b1;
          st_wd     = ST_SUSPENDED;
          cur_clr   = (cur_q == idx_q);
        end
      end
      KIND_KILL: begin
        if (!valid_idx || st_rd_q == ST_UNUSED) begin
          rc = RC_INVALID;
        end else begin
          do_unlink = (st_rd_q == ST_READY);
          st_we     = 1'b1;
          st_wd     = ST_KILLED;
          ex_we     = 1'b1;
          cur_clr   = (cur_q == idx_q);
          if (idx_q == RootTask) begin
            rc = RC_ROOT_KILLED;
          end
        end
      end
      KIND_YIELD: begin
        acted = cur_q;
        st_wa = cur_q;
        lt    = cur_q;
        if (cur_q == '0) begin
          rc = RC_ILLEGAL;
        end else begin
          st_we   = 1'b1;
          st_wd   = ST_READY;
          do_push = 1'b1;
          cur_clr = 1'b1;
        end
      end
      KIND_DISPATCH: begin
        acted = '0;
        st_wa = head_q;
        lt    = head_q;
        if (cur_q != '0) begin
          rc = RC_ILLEGAL;
        end else if (!nonempty_q) begin
          rc = RC_EMPTY;
        end else begin
          acted     = head_q;
          do_unlink = 1'b1;
          st_we     = 1'b1;
          st_wd     = ST_RUNNING;
          cur_set   = 1'b1;
        end
      end
      default: begin
        rc = RC_ILLEGAL;
      end
    endcase
  end

  // Link updates: append at the tail or splice a task out.
  always_comb begin
    prev_we    = 1'b0;
    prev_wa    = lt;
    prev_wd    = tail_q;
    next_we    = 1'b0;
    next_wa    = tail_q;
    next_wd    = lt;
    head_d     = head_q;
    tail_d     = tail_q;
    nonempty_d = nonempty_q;
    if (do_push) begin
      if (nonempty_q) begin
        prev_we = 1'b1;
        next_we = 1'b1;
        tail_d  = lt;
      end else begin
        head_d     = lt;
        tail_d     = lt;
        nonempty_d = 1'b1;
      end
    end else if (do_unlink) begin
      if (head_q == lt && tail_q == lt) begin
        head_d     = '0;
        tail_d     = '0;
        nonempty_d = 1'b0;
      end else begin
        if (head_q == lt) begin
          head_d = next_rd_q;
        end else begin
          next_we = 1'b1;
          next_wa = prev_rd_q;
          next_wd = next_rd_q;
        end
        if (tail_q == lt) begin
          tail_d = prev_rd_q;
        end else begin
          prev_we = 1'b1;
          prev_wa = next_rd_q;
          prev_wd = prev_rd_q;
        end
      end
    end
  end

  always_comb begin
    cur_d = cur_q;
    if (cur_clr) begin
      cur_d = '0;
    end else if (cur_set) begin
      cur_d = head_q;
    end
  end

  always_comb begin
    if (acted == '0) begin
      new_state = ST_UNUSED;
    end else if (st_we) begin
      new_state = st_wd;
    end else begin
      new_state = st_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (st_we) begin
        state_mem[st_wa] <= st_wd;
      end
      if (ex_we) begin
        exit_mem[st_wa] <= ex_wd;
      end
      if (prev_we) begin
        prev_mem[prev_wa] <= prev_wd;
      end
      if (next_we) begin
        next_mem[next_wa] <= next_wd;
      end
      status_q    <= rc;
      acted_q     <= acted;
      new_state_q <= new_state;
      running_q   <= cur_d;
      empty_q     <= ~nonempty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      nonempty_q <= 1'b0;
      cur_q      <= '0;
    end else if (cmd_i.commit) begin
      if (st_we) begin
        st_valid_q[st_wa] <= 1'b1;
      end
      head_q     <= head_d;
      tail_q     <= tail_d;
      nonempty_q <= nonempty_d;
      cur_q      <= cur_d;
    end
  end

  assign status_o         = status_q;
  assign acted_task_o     = acted_q;
  assign new_state_o      = new_state_q;
  assign running_task_o   = running_q;
  assign queue_is_empty_o = empty_q;

endmodule

// ===== sim/tb_task_state_ready_queue.sv =====
// ---------------------------------------------------------------------------
// tb_task_state_ready_queue
// Self-checking bench for the task table and ready queue. A short directed
// sequence walks the queue through head, middle and tail unlinks, dispatch,
// yield, suspend and kill, including the root task and the reserved kinds.
// A long random sequence then follows. Most random requests that name a task
// pick one whose tracked state suits the request, so the queue stays busy. Both stream sides
// idle at random. Every result word is checked field by field against a
// task table kept inside the bench.
// ---------------------------------------------------------------------------
module tb_task_state_ready_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import tsrq_pkg::*;

  // Kind codes that the package leaves unnamed; the block must reject them.
  localparam logic [KindW-1:0] KIND_RSVD_A = 3'd6;
  localparam logic [KindW-1:0] KIND_RSVD_B = 3'd7;

  localparam int unsigned RandomRequests = 650;
  localparam int unsigned DrainCycles    = 20;

  // One expected result word, fields as the block reports them.
  typedef struct {
    rc_e         status;
    task_t       acted;
    task_state_e state;
    task_t       running;
    logic        empty;
  } sched_result_t;

  // Task table, ready queue and the results still owed by the block.
  class run_queue_scoreboard;
    task_state_e      state_tab[MaxTasks];
    task_t            prev_tab[MaxTasks];
    task_t            next_tab[MaxTasks];
    logic [CodeW-1:0] exit_tab[MaxTasks];
    task_t            head;
    task_t            tail;
    task_t            cur;
    logic             nonempty;
    sched_result_t    expected_q[$];
    int unsigned      errors;

    function new();
      foreach (state_tab[i]) begin
        state_tab[i] = ST_UNUSED;
        prev_tab[i]  = '0;
        next_tab[i]  = '0;
        exit_tab[i]  = '0;
      end
      head     = '0;
      tail     = '0;
      cur      = '0;
      nonempty = 1'b0;
      errors   = 0;
    endfunction

    // Append a task at the queue tail.
    function void enqueue_ready(task_t t);
      prev_tab[t] = '0;
      next_tab[t] = '0;
      if (!nonempty) begin
        head     = t;
        tail     = t;
        nonempty = 1'b1;
      end else begin
        next_tab[tail] = t;
        prev_tab[t]    = tail;
        tail           = t;
      end
    endfunction

    // Remove a queued task wherever it sits and patch its neighbours.
    function void unlink_ready(task_t t);
      task_t p;
      task_t n;
      p = prev_tab[t];
      n = next_tab[t];
      if (head == t && tail == t) begin
        nonempty = 1'b0;
        head     = '0;
        tail     = '0;
      end else begin
        if (head == t) head = n;
        else next_tab[p] = n;
        if (tail == t) tail = p;
        else prev_tab[n] = p;
      end
      prev_tab[t] = '0;
      next_tab[t] = '0;
    endfunction

    // Apply one accepted request to the table and queue its result.
    function void note_request(logic [KindW-1:0] kind, task_t idx, logic [CodeW-1:0] code);
      sched_result_t exp_r;
      logic          valid;
      task_state_e   st;
      rc_e           rc;
      task_t         acted;
      rc    = RC_OK;
      acted = idx;
      valid = (idx != '0);
      st    = valid ? state_tab[idx] : ST_UNUSED;
      if (kind <= KIND_KILL && (!valid || (kind != KIND_CREATE && st == ST_UNUSED))) begin
        rc = RC_INVALID;
      end else begin
        case (kind)
          KIND_CREATE: begin
            if (st != ST_UNUSED) begin
              rc = RC_ILLEGAL;
            end else begin
              state_tab[idx] = ST_SUSPENDED;
              exit_tab[idx]  = '0;
            end
          end
          KIND_RESUME: begin
            if (st != ST_SUSPENDED) begin
              rc = RC_ILLEGAL;
            end else begin
              state_tab[idx] = ST_READY;
              enqueue_ready(idx);
            end
          end
          KIND_SUSPEND: begin
            if (st == ST_KILLED) begin
              rc = RC_ILLEGAL;
            end else if (st != ST_SUSPENDED) begin
              if (st == ST_READY) unlink_ready(idx);
              state_tab[idx] = ST_SUSPENDED;
              if (cur == idx) cur = '0;
            end
          end
          KIND_KILL: begin
            if (st == ST_READY) unlink_ready(idx);
            state_tab[idx] = ST_KILLED;
            exit_tab[idx]  = code;
            if (cur == idx) cur = '0;
            if (idx == RootTask) rc = RC_ROOT_KILLED;
          end
          KIND_YIELD: begin
            acted = cur;
            if (cur == '0) begin
              rc = RC_ILLEGAL;
            end else begin
              state_tab[cur] = ST_READY;
              enqueue_ready(cur);
              cur = '0;
            end
          end
          KIND_DISPATCH: begin
            acted = '0;
            if (cur != '0) begin
              rc = RC_ILLEGAL;
            end else if (!nonempty) begin
              rc = RC_EMPTY;
            end else begin
              acted = head;
              unlink_ready(acted);
              state_tab[acted] = ST_RUNNING;
              cur = acted;
            end
          end
          default: rc = RC_ILLEGAL;
        endcase
      end
      exp_r.status  = rc;
      exp_r.acted   = acted;
      exp_r.state   = (acted == '0) ? ST_UNUSED : state_tab[acted];
      exp_r.running = cur;
      exp_r.empty   = !nonempty;
      expected_q.push_back(exp_r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Check one result word against the oldest expectation.
    function void check_result(logic [OutDataW-1:0] data, logic [RcW-1:0] rc);
      sched_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, expected none, actual tdata=%h tuser=%0d",
                 $time, data, rc);
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, rc);
      compare_field("acted_task", want.acted, data[TaskW-1:0]);
      compare_field("new_state", want.state, data[TaskW +: StateW]);
      compare_field("running_task", want.running, data[TaskW+StateW +: TaskW]);
      compare_field("queue_is_empty", want.empty, data[2*TaskW+StateW]);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Random nonzero task in the given state, or 0 when there is none.
    function task_t pick_task(task_state_e want);
      task_t hits[$];
      for (int i = 1; i < MaxTasks; i++) begin
        if (state_tab[i] == want) hits.push_back(task_t'(i));
      end
      if (hits.size() == 0) return '0;
      return hits[$urandom_range(0, hits.size() - 1)];
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata  = '0;
  logic [KindW-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [RcW-1:0]        m_axis_tuser;

  run_queue_scoreboard   board = new();
  int unsigned           tx_quiet = 0;
  int unsigned           rx_quiet = 0;

  task_state_ready_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Draw an idle length: mostly none or short, a few long, and now and then
  // a quiet stretch of words with no idling at all.
  function automatic int unsigned draw_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request word, hold it until taken, then log it.
  task automatic send_request(input logic [KindW-1:0] kind, input task_t idx,
                              input logic [CodeW-1:0] code);
    int unsigned gap;
    gap = draw_gap(tx_quiet);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({code, idx});
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(kind, idx, code);
  endtask

  // Result side: run ready for a while, then drop it for a random stall.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      stall = draw_gap(rx_quiet);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Check every result word the moment it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    int unsigned      r;
    logic             aim;
    task_state_e      want;
    task_t            idx;
    task_t            pick;
    logic [KindW-1:0] kind;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty and idle corner cases first.
    send_request(KIND_DISPATCH, task_t'(0), '0);
    send_request(KIND_YIELD, task_t'(0), '0);
    send_request(KIND_CREATE, task_t'(0), '0);
    send_request(KIND_RESUME, task_t'(5), '0);
    // Build tasks 1, 2 and 63 and queue them in that order.
    send_request(KIND_CREATE, task_t'(1), 32'hFFFF_FFFF);
    send_request(KIND_CREATE, task_t'(2), '0);
    send_request(KIND_CREATE, task_t'(63), '0);
    send_request(KIND_CREATE, task_t'(1), '0);
    send_request(KIND_RESUME, task_t'(1), '0);
    send_request(KIND_RESUME, task_t'(2), '0);
    send_request(KIND_RESUME, task_t'(63), '0);
    send_request(KIND_RESUME, task_t'(2), '0);
    // Unlink from the middle, dispatch the head, then yield it to the tail.
    send_request(KIND_SUSPEND, task_t'(2), '0);
    send_request(KIND_DISPATCH, task_t'(0), '0);
    send_request(KIND_DISPATCH, task_t'(0), '0);
    send_request(KIND_YIELD, task_t'(0), '0);
    // Unlink the tail, suspend twice, kill the sole queued task twice.
    send_request(KIND_SUSPEND, task_t'(1), '0);
    send_request(KIND_SUSPEND, task_t'(1), '0);
    send_request(KIND_KILL, task_t'(63), 32'h8000_0000);
    send_request(KIND_KILL, task_t'(63), 32'h7FFF_FFFF);
    send_request(KIND_SUSPEND, task_t'(63), '0);
    // Run the root task and kill it while it is current.
    send_request(KIND_RESUME, task_t'(1), '0);
    send_request(KIND_DISPATCH, task_t'(0), '0);
    send_request(KIND_KILL, task_t'(1), 32'hFFFF_FFFF);
    send_request(KIND_RSVD_A, task_t'(63), 32'h5555_AAAA);
    send_request(KIND_RSVD_B, task_t'(0), '0);

    // Random: create, resume, suspend and kill mostly aimed at a task in a fitting
    // state, the rest yield, dispatch, reserved kinds and fully random kinds.
    for (int n = 0; n < RandomRequests; n++) begin
      r    = $urandom_range(0, 99);
      aim  = ($urandom_range(0, 99) < 80);
      idx  = task_t'($urandom_range(0, MaxTasks - 1));
      want = ST_UNUSED;
      if (r < 14) begin
        kind = KIND_CREATE;
        want = ST_UNUSED;
      end else if (r < 32) begin
        kind = KIND_RESUME;
        want = ST_SUSPENDED;
      end else if (r < 45) begin
        kind = KIND_SUSPEND;
        case ($urandom_range(0, 2))
          0:       want = ST_READY;
          1:       want = ST_RUNNING;
          default: want = ST_SUSPENDED;
        endcase
      end else if (r < 50) begin
        kind = KIND_KILL;
        case ($urandom_range(0, 3))
          0:       want = ST_READY;
          1:       want = ST_RUNNING;
          2:       want = ST_SUSPENDED;
          default: want = ST_KILLED;
        endcase
      end else begin
        aim = 1'b0;
        if (r < 66) kind = KIND_YIELD;
        else if (r < 86) kind = KIND_DISPATCH;
        else if (r < 90) kind = $urandom_range(0, 1) ? KIND_RSVD_A : KIND_RSVD_B;
        else kind = KindW'($urandom_range(0, 7));
      end
      if (aim) begin
        pick = board.pick_task(want);
        if (pick != '0) idx = pick;
      end
      send_request(kind, idx, $urandom());
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every owed result, then keep watching for strays.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d results still owed", $time, board.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
